@@ rtl/mcw_pkg.sv @@
// Shared constants and field widths of the multi-channel watchdog.
package mcw_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MAX_CHAN     = 16;

    localparam int CMD_W   = 3;
    localparam int CHAN_W  = 4;
    localparam int TIME_W  = 16;
    localparam int MASK_W  = 3;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 2 * TIME_W;

    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FEED    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_TIME = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INACTIVE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    localparam int MASK_EN   = 0;
    localparam int MASK_WARN = 1;
    localparam int MASK_RST  = 2;

endpackage

@@ rtl/mcw_if.sv @@
// Request and response channel interfaces of the multi-channel watchdog.
interface mcw_req_if;
    import mcw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [CHAN_W-1:0]        channel;
    logic signed [TIME_W-1:0] timeout;
    logic [MASK_W-1:0]        flag_mask;

    modport source (output valid, command, channel, timeout, flag_mask, input ready);
    modport sink (input valid, command, channel, timeout, flag_mask, output ready);
endinterface

interface mcw_rsp_if;
    import mcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan_out;
    logic [STAT_W-1:0] status;
    logic              warn;
    logic              reset_request;
    logic              last;

    modport source (output valid, kind, chan_out, status, warn, reset_request, last,
                    input ready);
    modport sink (input valid, kind, chan_out, status, warn, reset_request, last,
                  output ready);
endinterface

@@ rtl/multi_channel_watchdog.sv @@
// Multi-channel watchdog: a bank of up to sixteen countdown channels driven by
// create, destroy, feed, set-flags, clear-flags and tick requests. Each request
// gives its response items on the response channel in order; the last one has
// last set. Create, destroy, set and clear are answered from the idle state;
// feed passes through ST_FEED because it reads the reload value from the
// counter memory first. A tick walks the channels one per cycle through the
// single read port of that memory, holding the walk while the response
// side stalls an expiry event. Requests with codes six and seven are dropped
// without a response. One response waits in an output register, and a new
// request is taken no earlier than the cycle in which that response leaves.
module multi_channel_watchdog #(
    parameter int CHANNELS = mcw_pkg::CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcw_req_if.sink    i_req,
    mcw_rsp_if.source  o_rsp
);
    import mcw_pkg::*;

    localparam int NCH   = (CHANNELS > MAX_CHAN) ? MAX_CHAN : CHANNELS;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_TICK,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    logic [NCH-1:0] r_active, n_active;
    logic [NCH-1:0] r_enabled, n_enabled;
    logic [NCH-1:0] r_warn_en, n_warn_en;
    logic [NCH-1:0] r_rst_en, n_rst_en;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_ch, n_ch;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [CHAN_W-1:0] r_chan, n_chan;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_warn, n_warn;
    logic              r_rst_req, n_rst_req;
    logic              r_last, n_last;

    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_rd_data;

    logic              w_can_push;
    logic              w_accept;
    logic [IDX_W-1:0]  w_req_idx;
    logic              w_live;
    logic              w_free_found;
    logic [IDX_W-1:0]  w_free_idx;
    logic              w_tpos;
    logic              w_set_val;
    logic [TIME_W-1:0] w_cnt;
    logic [TIME_W-1:0] w_rel;
    logic              w_expire;

    mcw_mem #(
        .DEPTH  (NCH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_can_push   = !r_out_valid || o_rsp.ready;
    assign i_req.ready  = (r_state == ST_IDLE) && w_can_push;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_req_idx    = i_req.channel[IDX_W-1:0];
    assign w_live       = ({1'b0, i_req.channel} < (CHAN_W + 1)'(NCH)) && r_active[w_req_idx];
    assign w_tpos       = i_req.timeout > 16'sd0;
    assign w_set_val    = (i_req.command == CMD_SET);
    assign w_cnt        = w_rd_data[ENTRY_W-1:TIME_W];
    assign w_rel        = w_rd_data[TIME_W-1:0];
    assign w_expire     = (w_cnt == '0) || w_cnt[TIME_W-1];

    // Lowest free channel.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = NCH - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_enabled   = r_enabled;
        n_warn_en   = r_warn_en;
        n_rst_en    = r_rst_en;
        n_idx       = r_idx;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_kind      = r_kind;
        n_chan      = r_chan;
        n_status    = r_status;
        n_warn      = r_warn;
        n_rst_req   = r_rst_req;
        n_last      = r_last;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_req_idx;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = {w_rel, w_rel};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind    = KIND_REPLY;
                    n_chan    = i_req.channel;
                    n_status  = STAT_OK;
                    n_warn    = 1'b0;
                    n_rst_req = 1'b0;
                    n_last    = 1'b1;
                    unique case (i_req.command)
                        CMD_TICK: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = '0;
                            n_idx     = '0;
                            n_state   = ST_TICK;
                        end
                        CMD_CREATE: begin
                            n_out_valid = 1'b1;
                            if (!w_free_found) begin
                                n_chan   = '0;
                                n_status = STAT_FULL;
                            end else if (!w_tpos) begin
                                n_chan   = '0;
                                n_status = STAT_BAD_TIME;
                            end else begin
                                n_chan                = CHAN_W'(w_free_idx);
                                n_active[w_free_idx]  = 1'b1;
                                n_enabled[w_free_idx] = 1'b1;
                                n_warn_en[w_free_idx] = 1'b1;
                                n_rst_en[w_free_idx]  = 1'b0;
                                w_wr_en               = 1'b1;
                                w_wr_addr             = w_free_idx;
                                w_wr_data             = {i_req.timeout, i_req.timeout};
                            end
                        end
                        CMD_DESTROY: begin
                            n_out_valid = 1'b1;
                            if (!w_live) begin
                                n_status = STAT_INACTIVE;
                            end else begin
                                n_active[w_req_idx]  = 1'b0;
                                n_enabled[w_req_idx] = 1'b0;
                                n_warn_en[w_req_idx] = 1'b0;
                                n_rst_en[w_req_idx]  = 1'b0;
                            end
                        end
                        CMD_FEED: begin
                            if (!w_live) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_INACTIVE;
                            end else begin
                                w_rd_en = 1'b1;
                                n_ch    = w_req_idx;
                                n_state = ST_FEED;
                            end
                        end
                        CMD_SET, CMD_CLEAR: begin
                            n_out_valid = 1'b1;
                            if (!w_live) begin
                                n_status = STAT_INACTIVE;
                            end else begin
                                if (i_req.flag_mask[MASK_EN]) begin
                                    n_enabled[w_req_idx] = w_set_val;
                                end
                                if (i_req.flag_mask[MASK_WARN]) begin
                                    n_warn_en[w_req_idx] = w_set_val;
                                end
                                if (i_req.flag_mask[MASK_RST]) begin
                                    n_rst_en[w_req_idx] = w_set_val;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FEED: begin
                if (w_can_push) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_ch;
                    w_wr_data   = {w_rel, w_rel};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_TICK: begin
                // The entry for r_idx is in the read register; an expiry that
                // cannot be sent holds the walk.
                if (!(r_active[r_idx] && r_enabled[r_idx] && w_expire && !w_can_push)) begin
                    if (r_active[r_idx] && r_enabled[r_idx]) begin
                        w_wr_en = 1'b1;
                        if (w_expire) begin
                            w_wr_data   = {w_rel, w_rel};
                            n_out_valid = 1'b1;
                            n_kind      = KIND_EVENT;
                            n_chan      = CHAN_W'(r_idx);
                            n_status    = STAT_OK;
                            n_warn      = r_warn_en[r_idx];
                            n_rst_req   = r_rst_en[r_idx];
                            n_last      = 1'b0;
                        end else begin
                            w_wr_data = {w_cnt - TIME_W'(1), w_rel};
                        end
                    end
                    if (r_idx == IDX_W'(NCH - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx     = r_idx + IDX_W'(1);
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + IDX_W'(1);
                    end
                end
            end
            ST_DONE: begin
                if (w_can_push) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DONE;
                    n_chan      = '0;
                    n_status    = STAT_OK;
                    n_warn      = 1'b0;
                    n_rst_req   = 1'b0;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_enabled   <= '0;
            r_warn_en   <= '0;
            r_rst_en    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_enabled   <= n_enabled;
            r_warn_en   <= n_warn_en;
            r_rst_en    <= n_rst_en;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_ch      <= n_ch;
        r_kind    <= n_kind;
        r_chan    <= n_chan;
        r_status  <= n_status;
        r_warn    <= n_warn;
        r_rst_req <= n_rst_req;
        r_last    <= n_last;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_kind;
    assign o_rsp.chan_out      = r_chan;
    assign o_rsp.status        = r_status;
    assign o_rsp.warn          = r_warn;
    assign o_rsp.reset_request = r_rst_req;
    assign o_rsp.last          = r_last;

    // Requests are only taken between walks and feeds.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> r_state == ST_IDLE)
        else $error("request accepted outside idle");

    // The tick walk only writes back channels that are counting.
    a_tick_write_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) && w_wr_en |-> r_active[r_idx] && r_enabled[r_idx])
        else $error("tick wrote an idle channel");

    // A walk ends only through the tick-done step.
    a_tick_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TICK |=> r_state == ST_TICK || r_state == ST_DONE)
        else $error("tick walk left early");

    // An expiry event never carries last and always reports status ok.
    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_EVENT) |-> !r_last && (r_status == STAT_OK))
        else $error("bad expiry event fields");

    // A feed writes back the channel it read.
    a_feed_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FEED) && w_wr_en |-> r_active[r_ch])
        else $error("feed wrote an inactive channel");

endmodule

@@ rtl/mcw_mem.sv @@
// Counter and reload memory: one write port, one registered read port.
module mcw_mem #(
    parameter int DEPTH  = mcw_pkg::CHANNELS_DEF,
    parameter int ADDR_W = 4
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [mcw_pkg::ENTRY_W-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [mcw_pkg::ENTRY_W-1:0]  o_rd_data
);
    import mcw_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled walk keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
